>>> design/ipv4hp_pkg.sv
// ============================================================================
// ipv4hp_pkg
// Shared types and constants for the IPv4 header parser and checksum checker.
// ============================================================================
package ipv4hp_pkg;

    localparam int WORD_W    = 32;
    localparam int CNT_W     = 5;
    localparam int SUM_W     = 21;
    localparam int HALF_W    = 16;
    localparam int NUM_FIXED = 5;
    localparam int IDX_W     = 3;
    localparam int DATA_W    = 144;
    localparam int USER_W    = 4;

    localparam logic [CNT_W-1:0]  MIN_WORDS = CNT_W'(5);
    localparam logic [CNT_W-1:0]  COUNT_MAX = CNT_W'(16);
    localparam logic [HALF_W-1:0] SUM_GOOD  = 16'hFFFF;

    // error codes, lowest value wins when several apply
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SHORT    = 3'd1,
        ERR_TRUNC    = 3'd2,
        ERR_LENGTH   = 3'd3,
        ERR_CHECKSUM = 3'd4
    } err_t;

    typedef logic [NUM_FIXED-1:0][WORD_W-1:0] hdr_words_t;

    typedef struct packed {
        logic        header_ok;
        err_t        error_code;
        logic [3:0]  version;
        logic [3:0]  ihl;
        logic [7:0]  tos;
        logic [15:0] tot_len;
        logic [15:0] identification;
        logic [15:0] flags_fragment;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
    } result_t;

endpackage

>>> design/ipv4hp_eval.sv
// ============================================================================
// ipv4hp_eval
// Decodes the fixed header words and checks length fields and checksum.
// ============================================================================
module ipv4hp_eval (
    input  logic [ipv4hp_pkg::CNT_W-1:0] word_count,
    input  logic [ipv4hp_pkg::SUM_W-1:0] sum,
    input  ipv4hp_pkg::hdr_words_t       hdr,
    output ipv4hp_pkg::result_t          result
);
    import ipv4hp_pkg::*;

    logic [HALF_W:0]   fold1;
    logic [HALF_W-1:0] fold2;
    logic [3:0]        ihl_f;
    logic [15:0]       tl_f;

    // two end-around folds, second one cannot carry out
    assign fold1 = {1'b0, sum[HALF_W-1:0]} + {12'b0, sum[SUM_W-1:HALF_W]};
    assign fold2 = fold1[HALF_W-1:0] + {15'b0, fold1[HALF_W]};

    assign ihl_f = hdr[0][27:24];
    assign tl_f  = hdr[0][15:0];

    always_comb
    begin
        result = '0;
        if (word_count < MIN_WORDS)
        begin
            result.error_code = ERR_SHORT;
        end
        else
        begin
            result.version        = hdr[0][31:28];
            result.ihl            = ihl_f;
            result.tos            = hdr[0][23:16];
            result.tot_len        = tl_f;
            result.identification = hdr[1][31:16];
            result.flags_fragment = hdr[1][15:0];
            result.ttl            = hdr[2][31:24];
            result.protocol       = hdr[2][23:16];
            result.source_addr    = hdr[3];
            result.dest_addr      = hdr[4];
            if ({1'b0, ihl_f} > word_count)
                result.error_code = ERR_TRUNC;
            else if ({1'b0, ihl_f} < MIN_WORDS || tl_f < {10'b0, ihl_f, 2'b00})
                result.error_code = ERR_LENGTH;
            else if (fold2 != SUM_GOOD)
                result.error_code = ERR_CHECKSUM;
            else
                result.error_code = ERR_NONE;
        end
        result.header_ok = (result.error_code == ERR_NONE);
    end

endmodule

>>> design/ipv4_header_parse_check_top.sv
// ============================================================================
// ipv4_header_parse_check_top
// IPv4 header parser: captures the fixed header, sums header halves and
// reports decoded fields with an error code on the last word of a buffer.
// ============================================================================
//
//  channel   dir  request contents
//  --------  ---  ---------------------------------------------------------
//  s_axis    in   tdata = word[31:0], tlast = last of buffer
//  m_axis    out  tdata = header fields, tuser = header_ok, error_code
//
//  One word per cycle sustained: each word is held in the input register,
//  where the running sum add and the result decode are done, then the result
//  of a last word goes to the output register. rst_n clears word count, sum
//  and both valid flags. A stalled output only holds back a last word; other
//  words keep flowing.
//
module ipv4_header_parse_check_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ipv4hp_pkg::WORD_W-1:0]     s_axis_tdata,  // word[31:0]
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // version[3:0], ihl[7:4], tos[15:8], tot_len[31:16],
    // identification[47:32], flags_fragment[63:48], ttl[71:64],
    // protocol[79:72], source_addr[111:80], dest_addr[143:112]
    output logic [ipv4hp_pkg::DATA_W-1:0]     m_axis_tdata,
    // header_ok[0], error_code[3:1]
    output logic [ipv4hp_pkg::USER_W-1:0]     m_axis_tuser
);
    import ipv4hp_pkg::*;

    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_last_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    hdr_words_t        hdr_reg;
    hdr_words_t        hdr_next;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           result;
    logic              advance;
    logic              capture;
    logic              in_header;
    logic [HALF_W:0]   half_sum;

    // input stage moves on unless a last word waits on a full output
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // per-word bookkeeping
    assign capture   = cnt_reg < MIN_WORDS;
    assign in_header = capture || (cnt_reg < {1'b0, hdr_reg[0][27:24]});
    assign half_sum  = {1'b0, in_word_reg[31:16]} + {1'b0, in_word_reg[15:0]};
    assign sum_next  = SUM_W'(sum_reg + (in_header ? {4'b0, half_sum} : '0));
    assign cnt_next  = (cnt_reg == COUNT_MAX) ? COUNT_MAX : cnt_reg + CNT_W'(1);

    always_comb
    begin
        hdr_next = hdr_reg;
        for (int j = 0; j < NUM_FIXED; j++)
        begin
            if (capture && cnt_reg[IDX_W-1:0] == IDX_W'(j))
                hdr_next[j] = in_word_reg;
        end
    end

    ipv4hp_eval u_eval (
        .word_count (cnt_next),
        .sum        (sum_next),
        .hdr        (hdr_next),
        .result     (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_word_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // buffer state, cleared after the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
        end
        else if (advance)
        begin
            cnt_reg <= in_last_reg ? '0 : cnt_next;
            sum_reg <= in_last_reg ? '0 : sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            hdr_reg <= hdr_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {out_reg.error_code, out_reg.header_ok};
    assign m_axis_tdata  = {out_reg.dest_addr, out_reg.source_addr, out_reg.protocol,
                            out_reg.ttl, out_reg.flags_fragment, out_reg.identification,
                            out_reg.tot_len, out_reg.tos, out_reg.ihl,
                            out_reg.version};

endmodule
